// ----- hdl/hgbs_pkg.sv -----
// Shared constants and types for the height grid bilinear sampler.
// Depends on nothing; used by heightgrid_bilinear_sampler and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package hgbs_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int GRID_WORDS = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(GRID_WORDS);
    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam int FRAC_W     = 16;
    localparam int T_W        = FRAC_W + IDX_W;
    localparam int H_W        = 32;
    localparam int PROD_W     = H_W + 1 + FRAC_W + 1;
    localparam int STEP_W     = PROD_W - FRAC_W;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef logic signed [H_W-1:0] height_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [FRAC_W-1:0]     frac_t;

endpackage

`default_nettype wire

// ----- hdl/heightgrid_bilinear_sampler.sv -----
// Height grid bilinear sampler: grid load with running maximum, bilinear query.
// Depends on hgbs_pkg and hgbs_ram.
//
// Usage: present a word on the input ports with start high; it is taken at a
// clock edge where start is high and busy is low.
//   mode = 0: height_sample is written at the next load address and folded into
//     the running maximum. Busy never rises, so loads go one per cycle. When
//     last_sample is set, done pulses in the next cycle with the maximum on
//     height_out and is_load_max high; address and maximum then return to zero.
//   mode = 1: coord_x / coord_y pick a grid cell and fraction; the four corner
//     heights are read one per cycle from the read port of the grid memory, then
//     blended by one shared lerp unit (multiply stage, round-and-add stage),
//     three lerps in a row. Busy stays high through the reads and the lerps,
//     so the next word is taken only once the query is through; done pulses
//     in the first cycle with busy low, with is_load_max low.
// done is high for exactly one cycle per result and cannot be held off.
// Reset clears the sequencer, load address, running maximum, done and the
// datapath registers. The grid memory is not cleared; query only cells that a
// load has written.
`timescale 1ns / 1ps
`default_nettype none

module heightgrid_bilinear_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [31:0] height_sample,
    input  wire logic [15:0] coord_x,
    input  wire logic [15:0] coord_y,
    input  wire logic        last_sample,
    output logic             done,
    output logic [31:0]      height_out,
    output logic             is_load_max
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ADD
    } state_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    state_t                        state_reg;
    logic [1:0]                    rd_cnt_reg;
    logic                          rd_pend_reg;
    logic [1:0]                    rd_sel_reg;
    logic [1:0]                    lerp_cnt_reg;
    logic [hgbs_pkg::T_W-1:0]      tx_reg;
    logic [hgbs_pkg::T_W-1:0]      ty_reg;
    hgbs_pkg::height_t             corner_reg [4];
    logic signed [hgbs_pkg::PROD_W-1:0] prod_reg;
    hgbs_pkg::height_t             p_hold_reg;
    hgbs_pkg::addr_t               load_addr_reg;
    hgbs_pkg::height_t             max_reg;
    logic                          done_reg;
    hgbs_pkg::height_t             height_out_reg;
    logic                          is_load_max_reg;

    logic                          accept;
    logic                          load_we;
    hgbs_pkg::height_t             sample;
    hgbs_pkg::height_t             max_next;
    hgbs_pkg::addr_t               load_addr_next;
    logic [hgbs_pkg::IDX_W-1:0]    x1;
    logic [hgbs_pkg::IDX_W-1:0]    y1;
    hgbs_pkg::addr_t               base_lo;
    hgbs_pkg::addr_t               base_hi;
    hgbs_pkg::addr_t               raddr_next;
    logic [31:0]                   rdata;
    hgbs_pkg::height_t             lerp_p;
    hgbs_pkg::height_t             lerp_q;
    hgbs_pkg::frac_t               lerp_f;
    logic signed [hgbs_pkg::H_W:0] lerp_diff;
    logic signed [hgbs_pkg::PROD_W-1:0] prod_next;
    logic [hgbs_pkg::PROD_W-1:0]   rounded;
    logic signed [hgbs_pkg::STEP_W-1:0] lerp_step;
    logic signed [hgbs_pkg::STEP_W-1:0] lerp_sum;
    hgbs_pkg::height_t             lerp_res;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign load_we     = accept && (mode == MODE_LOAD);
    assign done        = done_reg;
    assign height_out  = height_out_reg;
    assign is_load_max = is_load_max_reg;

    // Load path: running maximum and wrapping write address.
    assign sample   = hgbs_pkg::height_t'(height_sample);
    assign max_next = (sample > max_reg) ? sample : max_reg;
    assign load_addr_next = (load_addr_reg == hgbs_pkg::addr_t'(hgbs_pkg::GRID_WORDS - 1))
                            ? '0 : load_addr_reg + 1'b1;

    // Corner addresses; rows are stored flipped.
    assign x1 = tx_reg[hgbs_pkg::T_W-1:hgbs_pkg::FRAC_W];
    assign y1 = ty_reg[hgbs_pkg::T_W-1:hgbs_pkg::FRAC_W];
    assign base_lo = (hgbs_pkg::addr_t'(hgbs_pkg::GRID_SIZE - 1) - hgbs_pkg::addr_t'(y1))
                     * hgbs_pkg::addr_t'(hgbs_pkg::GRID_SIZE);
    assign base_hi = base_lo - hgbs_pkg::addr_t'(hgbs_pkg::GRID_SIZE);

    // Read order: h1, h4, h2, h3 into corner slots 0..3.
    always_comb
    begin
        case (rd_cnt_reg)
            2'd0:    raddr_next = base_lo + hgbs_pkg::addr_t'(x1);
            2'd1:    raddr_next = base_hi + hgbs_pkg::addr_t'(x1);
            2'd2:    raddr_next = base_lo + hgbs_pkg::addr_t'(x1) + 1'b1;
            default: raddr_next = base_hi + hgbs_pkg::addr_t'(x1) + 1'b1;
        endcase
    end

    hgbs_ram #(
        .WIDTH(hgbs_pkg::H_W),
        .DEPTH(hgbs_pkg::GRID_WORDS)
    ) u_grid (
        .clk  (clk),
        .we   (load_we),
        .waddr(load_addr_reg),
        .wdata(height_sample),
        .raddr(raddr_next),
        .rdata(rdata)
    );

    // Shared lerp operands: a = lerp(h1,h4,fy), b = lerp(h2,h3,fy), r = lerp(a,b,fx).
    always_comb
    begin
        case (lerp_cnt_reg)
            2'd0:
            begin
                lerp_p = corner_reg[0];
                lerp_q = corner_reg[1];
                lerp_f = ty_reg[hgbs_pkg::FRAC_W-1:0];
            end
            2'd1:
            begin
                lerp_p = corner_reg[2];
                lerp_q = corner_reg[3];
                lerp_f = ty_reg[hgbs_pkg::FRAC_W-1:0];
            end
            default:
            begin
                lerp_p = corner_reg[0];
                lerp_q = corner_reg[2];
                lerp_f = tx_reg[hgbs_pkg::FRAC_W-1:0];
            end
        endcase
    end

    assign lerp_diff = {lerp_q[hgbs_pkg::H_W-1], lerp_q} - {lerp_p[hgbs_pkg::H_W-1], lerp_p};
    assign prod_next = hgbs_pkg::PROD_W'(lerp_diff * $signed({1'b0, lerp_f}));

    // Add half an LSB, then floor: halves round toward plus infinity.
    assign rounded   = prod_reg + hgbs_pkg::ROUND_HALF;
    assign lerp_step = rounded[hgbs_pkg::PROD_W-1:hgbs_pkg::FRAC_W];
    assign lerp_sum  = hgbs_pkg::STEP_W'(p_hold_reg) + lerp_step;
    assign lerp_res  = lerp_sum[hgbs_pkg::H_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rd_cnt_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            rd_sel_reg      <= '0;
            lerp_cnt_reg    <= '0;
            tx_reg          <= '0;
            ty_reg          <= '0;
            corner_reg      <= '{default: '0};
            prod_reg        <= '0;
            p_hold_reg      <= '0;
            load_addr_reg   <= '0;
            max_reg         <= '0;
            done_reg        <= 1'b0;
            height_out_reg  <= '0;
            is_load_max_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;

            // Capture read data in the cycle after the address went out.
            if (rd_pend_reg)
            begin
                corner_reg[rd_sel_reg] <= rdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (mode == MODE_LOAD))
                    begin
                        if (last_sample)
                        begin
                            done_reg        <= 1'b1;
                            height_out_reg  <= max_next;
                            is_load_max_reg <= 1'b1;
                            load_addr_reg   <= '0;
                            max_reg         <= '0;
                        end
                        else
                        begin
                            load_addr_reg <= load_addr_next;
                            max_reg       <= max_next;
                        end
                    end
                    else if (accept && (mode == MODE_QUERY))
                    begin
                        tx_reg       <= hgbs_pkg::T_W'(coord_x) *
                                        hgbs_pkg::T_W'(hgbs_pkg::GRID_SIZE - 1);
                        ty_reg       <= hgbs_pkg::T_W'(coord_y) *
                                        hgbs_pkg::T_W'(hgbs_pkg::GRID_SIZE - 1);
                        rd_cnt_reg   <= '0;
                        lerp_cnt_reg <= '0;
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_pend_reg <= 1'b1;
                    rd_sel_reg  <= rd_cnt_reg;
                    rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 2'd3)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg   <= prod_next;
                    p_hold_reg <= lerp_p;
                    state_reg  <= S_ADD;
                end
                S_ADD:
                begin
                    lerp_cnt_reg <= lerp_cnt_reg + 1'b1;
                    unique case (lerp_cnt_reg)
                        2'd0:
                        begin
                            corner_reg[0] <= lerp_res;
                            state_reg     <= S_MUL;
                        end
                        2'd1:
                        begin
                            corner_reg[2] <= lerp_res;
                            state_reg     <= S_MUL;
                        end
                        default:
                        begin
                            done_reg        <= 1'b1;
                            height_out_reg  <= lerp_res;
                            is_load_max_reg <= 1'b0;
                            state_reg       <= S_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_QUERY) |=> busy)
        else $error("query accepted but sequencer did not start");

    a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_LOAD && last_sample) |=>
            (done && is_load_max && load_addr_reg == '0 && max_reg == '0))
        else $error("last load word did not emit maximum and clear state");

    a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_load_max) |-> $past(state_reg == S_ADD && lerp_cnt_reg == 2'd2))
        else $error("query result without final lerp");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !load_we)
        else $error("grid written during a query");

endmodule

`default_nettype wire

// ----- hdl/hgbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hgbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- tb/heightgrid_bilinear_sampler_test.sv -----
// Self-checking testbench for the height grid bilinear sampler: grid loads with
// running maximum and bilinear queries over the loaded rows of the grid.
// Depends on hgbs_pkg and on the heightgrid_bilinear_sampler RTL.
`timescale 1ns / 1ps

module heightgrid_bilinear_sampler_test;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_QUERY    = 1'b1;
    localparam int   RANDOM_WORDS  = 370;
    localparam int   DRAIN_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 30;
    localparam int   WANT_DEPTH    = 64;
    // The first memory rows hold the top grid rows; queries stay inside them.
    localparam int   LOADED_ROWS   = 4;
    localparam int   LOADED_WORDS  = LOADED_ROWS * hgbs_pkg::GRID_SIZE;
    localparam int   Y_FLOOR       =
        ((hgbs_pkg::GRID_SIZE - LOADED_ROWS) * 65536 + hgbs_pkg::GRID_SIZE - 2)
        / (hgbs_pkg::GRID_SIZE - 1);

    typedef struct packed {
        hgbs_pkg::height_t height;
        logic              is_max;
    } sample_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [31:0] height_sample;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic        last_sample;
    logic        done;
    logic [31:0] height_out;
    logic        is_load_max;

    // Shadow of the block state
    hgbs_pkg::height_t grid_copy [hgbs_pkg::GRID_WORDS];
    int                next_load_addr;
    hgbs_pkg::height_t load_peak;

    // Expected result words in order
    sample_result_t want_fifo [WANT_DEPTH];
    int             want_wr = 0;
    int             want_rd = 0;

    int  mismatch_count = 0;
    int  loads_sent     = 0;
    int  queries_sent   = 0;
    int  results_seen   = 0;
    bit  steady         = 1'b0;

    heightgrid_bilinear_sampler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .height_sample (height_sample),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .last_sample   (last_sample),
        .done          (done),
        .height_out    (height_out),
        .is_load_max   (is_load_max)
    );

    always #1 clk = ~clk;

    function automatic void add_wanted(sample_result_t res);
        want_fifo[want_wr % WANT_DEPTH] = res;
        want_wr++;
    endfunction

    function automatic longint grid_corner(int x, int y);
        return longint'(grid_copy[hgbs_pkg::GRID_SIZE * (hgbs_pkg::GRID_SIZE - 1 - y) + x]);
    endfunction

    // p + round((q - p) * f / 2^16), halves toward plus infinity
    function automatic longint blend(longint p, longint q, longint f);
        longint prod;
        prod = (q - p) * f;
        return p + ((prod + 64'sd32768) >>> 16);
    endfunction

    function automatic void predict_word(logic m, logic [31:0] h, logic [15:0] cx,
                                         logic [15:0] cy, logic last);
        logic [31:0]    tx;
        logic [31:0]    ty;
        int             x1;
        int             y1;
        longint         a;
        longint         b;
        sample_result_t res;
        if (m == MODE_LOAD) begin
            grid_copy[next_load_addr] = hgbs_pkg::height_t'(h);
            if (hgbs_pkg::height_t'(h) > load_peak)
                load_peak = hgbs_pkg::height_t'(h);
            next_load_addr = (next_load_addr + 1) % hgbs_pkg::GRID_WORDS;
            if (last) begin
                res.height = load_peak;
                res.is_max = 1'b1;
                add_wanted(res);
                next_load_addr = 0;
                load_peak      = '0;
            end
        end
        else begin
            tx = 32'(cx) * 32'(hgbs_pkg::GRID_SIZE - 1);
            ty = 32'(cy) * 32'(hgbs_pkg::GRID_SIZE - 1);
            x1 = int'(tx >> 16);
            y1 = int'(ty >> 16);
            a = blend(grid_corner(x1, y1), grid_corner(x1, y1 + 1), longint'(ty[15:0]));
            b = blend(grid_corner(x1 + 1, y1), grid_corner(x1 + 1, y1 + 1),
                      longint'(ty[15:0]));
            res.height = hgbs_pkg::height_t'(blend(a, b, longint'(tx[15:0])));
            res.is_max = 1'b0;
            add_wanted(res);
        end
    endfunction

    function automatic logic [31:0] rand_height();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // y coordinates that land in the loaded rows only
    function automatic logic [15:0] rand_coord_y();
        case ($urandom_range(7))
            0: return 16'(Y_FLOOR);
            1: return 16'hFFFF;
            2: return 16'hF800;
            default: return 16'($urandom_range(32'hFFFF, Y_FLOOR));
        endcase
    endfunction

    // Drive one word and hold it until the block takes it
    task automatic send_word(logic m, logic [31:0] h, logic [15:0] cx, logic [15:0] cy,
                             logic last);
        if (!steady) begin
            while ($urandom_range(99) < 9) begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start         <= 1'b1;
        mode          <= m;
        height_sample <= h;
        coord_x       <= cx;
        coord_y       <= cy;
        last_sample   <= last;
        do
            @(posedge clk);
        while (busy);
        predict_word(m, h, cx, cy, last);
        if (m == MODE_LOAD)
            loads_sent++;
        else
            queries_sent++;
    endtask

    always @(posedge clk) begin : check_results
        sample_result_t want;
        if (rst_n && done) begin
            results_seen++;
            if (want_wr == want_rd) begin
                mismatch_count++;
                $error("unexpected result word: height_out %h is_load_max %b",
                       height_out, is_load_max);
            end
            else begin
                want = want_fifo[want_rd % WANT_DEPTH];
                want_rd++;
                if (height_out !== want.height) begin
                    mismatch_count++;
                    $error("height_out: expected %h, got %h", want.height, height_out);
                end
                if (is_load_max !== want.is_max) begin
                    mismatch_count++;
                    $error("is_load_max: expected %b, got %b", want.is_max, is_load_max);
                end
            end
        end
    end

    // Fill the top grid rows; the first two memory rows get alternating extremes
    // so queries near the top edge see full-range blends.
    task automatic test_grid_load();
        int          addr;
        logic [31:0] h;
        for (int i = 0; i < LOADED_WORDS; i++) begin
            addr = i;
            if (addr < 2 * hgbs_pkg::GRID_SIZE)
                h = (addr[0] ^ addr[6]) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                h = rand_height();
            send_word(MODE_LOAD, h, 16'($urandom), 16'($urandom), i == LOADED_WORDS - 1);
        end
    endtask

    // Edges of the coordinate range; last_sample and height_sample must be ignored
    task automatic test_query_corners();
        logic [15:0] xs [9] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
                                16'h0001, 16'hFFFE, 16'h0410, 16'hFBEF};
        logic [15:0] ys [9] = '{16'hFFFF, 16'hFFFF, 16'(Y_FLOOR), 16'(Y_FLOOR), 16'hF800,
                                16'hFFFE, 16'hFBF0, 16'hFFFE, 16'(Y_FLOOR + 1)};
        for (int i = 0; i < 9; i++)
            send_word(MODE_QUERY, $urandom, xs[i], ys[i], 1'b1);
    endtask

    // Running maximum starts from zero and clears after every last sample
    task automatic test_load_max();
        send_word(MODE_LOAD, 32'hFFFF_0000, '0, '0, 1'b0);
        send_word(MODE_LOAD, 32'h8000_0000, '0, '0, 1'b0);
        send_word(MODE_LOAD, 32'hFFFF_FFFF, '0, '0, 1'b1);
        send_word(MODE_LOAD, 32'h7FFF_FFFF, '0, '0, 1'b1);
        send_word(MODE_LOAD, 32'h8000_0000, '0, '0, 1'b1);
        send_word(MODE_LOAD, 32'h0000_0000, '0, '0, 1'b1);
        send_word(MODE_LOAD, 32'h0000_0001, '0, '0, 1'b0);
        send_word(MODE_QUERY, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(MODE_LOAD, 32'h0000_0000, '0, '0, 1'b1);
    endtask

    // Queries interleaved with short loads of random length; loads overwrite from
    // address zero, so every queried cell stays written
    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 120 && n < 260);
            if ($urandom_range(99) < 60)
                send_word(MODE_QUERY, $urandom, rand_coord(), rand_coord_y(),
                          1'($urandom));
            else
                send_word(MODE_LOAD, rand_height(), 16'($urandom), 16'($urandom),
                          $urandom_range(11) == 0);
        end
        steady = 1'b0;
    endtask

    initial begin
        int drain;
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = MODE_LOAD;
        height_sample  = '0;
        coord_x        = '0;
        coord_y        = '0;
        last_sample    = 1'b0;
        next_load_addr = 0;
        load_peak      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_grid_load();
        test_query_corners();
        test_load_max();
        test_random_mix();

        @(negedge clk);
        start <= 1'b0;
        drain = 0;
        while (want_wr != want_rd && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        if (want_wr != want_rd) begin
            $display("%0d result words never arrived", want_wr - want_rd);
            $display("*** FAILED ***");
            $finish;
        end
        else begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            $display("Sent %0d load words and %0d queries over the loaded top grid rows;",
                     loads_sent, queries_sent);
            $display("checked %0d result words, %0d mismatches.", results_seen, mismatch_count);
            if (mismatch_count == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        #5_000_000;
        $display("Run did not complete in time");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
